// ----- rtl/bpsuf_pkg.sv -----
// Package for the bottleneck pair-sum union-find engine.
// Holds the widths, reset constants and the input and result item structs.
package bpsuf_pkg;
	localparam int MaxNodes = 1024;
	localparam int IdxW = $clog2(MaxNodes);
	localparam int CntW = IdxW + 1;
	localparam int CapW = 30;
	localparam int SumW = 50;
	localparam logic [CapW-1:0] CapInit = {CapW{1'b1}};

	typedef struct packed {
		logic [IdxW-1:0] node_a;
		logic [IdxW-1:0] node_b;
		logic [CapW-1:0] capacity;
	} edge_item_t;

	typedef struct packed {
		logic            joined;
		logic [SumW-1:0] pair_sum;
	} result_item_t;
endpackage

// ----- rtl/bpsuf_edge_if.sv -----
// Valid/ready channel that carries one edge item.
// Depends on bpsuf_pkg.
interface bpsuf_edge_if;
	logic valid;
	logic ready;
	bpsuf_pkg::edge_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/bpsuf_result_if.sv -----
// Valid/ready channel that carries one result item.
// Depends on bpsuf_pkg.
interface bpsuf_result_if;
	logic valid;
	logic ready;
	bpsuf_pkg::result_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/bottleneck_pair_sum_union_find.sv -----
// Top level of the bottleneck pair-sum union-find engine.
// Depends on bpsuf_pkg, bpsuf_edge_if and bpsuf_result_if.
//
//   channel   dir  item
//   edges     in   node_a, node_b, capacity
//   results   out  joined, pair_sum
//   cfg       in   node_count write (cfg_we, cfg_data)
//
// Each find reads and checks the root, and every step below it goes through
// read, check, grandparent read and relink, over both parent chains.
// A merge then reads both set sizes and minima: one shared 32x32 multiplier is used twice,
// first for the product of the set sizes, then to scale it by the minimum.
// An out-of-range edge goes straight to its result. Chains stay short
// through union by size and path halving.
// After reset and after a node_count write a clearing pass sweeps the
// memories; no edge is accepted meanwhile.
// A result waits in its output register; the next edge is taken once it
// is delivered.
module bottleneck_pair_sum_union_find (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bpsuf_pkg::CntW-1:0] cfg_data,
	bpsuf_edge_if.sink                 edges,
	bpsuf_result_if.source             results
);
	localparam int IdxW = bpsuf_pkg::IdxW;
	localparam int CntW = bpsuf_pkg::CntW;
	localparam int CapW = bpsuf_pkg::CapW;
	localparam int SumW = bpsuf_pkg::SumW;

	localparam logic [3:0] StClr = 4'd0, StIdle = 4'd1, StFRd = 4'd2, StFChk = 4'd3,
		StFGp = 4'd4, StFLink = 4'd5, StMRd = 4'd6, StMWait = 4'd7, StMul1 = 4'd8,
		StMul2 = 4'd9, StAdd = 4'd10, StOut = 4'd11, StMWait2 = 4'd13;

	logic [3:0]      state_q;
	logic [IdxW-1:0] clr_q;
	logic [CntW-1:0] count_q;
	logic [SumW-1:0] total_q;
	logic [IdxW-1:0] a_q, b_q, cur_q, ra_q;
	logic [CapW-1:0] cap_q, m_q;
	logic            second_q;
	logic [CntW-1:0] sza_q, szb_q;
	logic [CapW-1:0] mina_q;
	logic [63:0]     prod_q;
	logic            out_valid_q, joined_q;

	logic [IdxW-1:0] parent_mem [bpsuf_pkg::MaxNodes];
	logic [CntW-1:0] size_mem   [bpsuf_pkg::MaxNodes];
	logic [CapW-1:0] minc_mem   [bpsuf_pkg::MaxNodes];

	// memory ports: one address for all three, registered read
	logic            p_we, s_we, c_we;
	logic [IdxW-1:0] mem_addr, p_wd;
	logic [CntW-1:0] s_wd;
	logic [CapW-1:0] c_wd;
	logic [IdxW-1:0] p_rd_q;
	logic [CntW-1:0] s_rd_q;
	logic [CapW-1:0] c_rd_q;

	always_ff @(posedge clk) begin
		if (p_we) parent_mem[mem_addr] <= p_wd;
		if (s_we) size_mem[mem_addr] <= s_wd;
		if (c_we) minc_mem[mem_addr] <= c_wd;
		p_rd_q <= parent_mem[mem_addr];
		s_rd_q <= size_mem[mem_addr];
		c_rd_q <= minc_mem[mem_addr];
	end

	// shared multiplier, operands muxed by state
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic [CntW-1:0] cfg_sat;
	always_comb begin
		cfg_sat = cfg_data;
		if (cfg_data == '0) cfg_sat = CntW'(1);
		if (cfg_data > CntW'(bpsuf_pkg::MaxNodes)) cfg_sat = CntW'(bpsuf_pkg::MaxNodes);
	end

	logic keep_b;
	assign keep_b = !(sza_q > szb_q);

	always_comb begin
		p_we = 1'b0; s_we = 1'b0; c_we = 1'b0;
		mem_addr = cur_q;
		p_wd = clr_q; s_wd = CntW'(1); c_wd = bpsuf_pkg::CapInit;
		mul_a = 32'(sza_q); mul_b = 32'(szb_q);
		unique case (state_q)
			StClr: begin
				mem_addr = clr_q; p_we = 1'b1; s_we = 1'b1; c_we = 1'b1;
			end
			StFGp: mem_addr = p_rd_q;
			StFLink: begin
				p_we = 1'b1; p_wd = p_rd_q;
			end
			StMRd: mem_addr = ra_q;
			StMWait: mem_addr = cur_q;
			StMul1: begin
				mul_a = 32'(sza_q); mul_b = 32'(szb_q);
			end
			StMul2: begin
				// size product fits in 22 bits
				mul_a = 32'(m_q); mul_b = prod_q[31:0];
				mem_addr = keep_b ? cur_q : ra_q;
				s_we = 1'b1; s_wd = sza_q + szb_q;
				c_we = 1'b1; c_wd = m_q;
			end
			StAdd: begin
				mem_addr = keep_b ? ra_q : cur_q;
				p_we = 1'b1; p_wd = keep_b ? cur_q : ra_q;
			end
			default: ;
		endcase
	end

	assign edges.ready = (state_q == StIdle) && !out_valid_q && !cfg_we;
	assign results.valid = out_valid_q;
	assign results.data.joined = joined_q;
	assign results.data.pair_sum = total_q;

	logic [CapW-1:0] m_sel;
	always_comb begin
		m_sel = (mina_q < c_rd_q) ? mina_q : c_rd_q;
		if (cap_q < m_sel) m_sel = cap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StClr; clr_q <= '0; count_q <= CntW'(bpsuf_pkg::MaxNodes);
			total_q <= '0; out_valid_q <= 1'b0; second_q <= 1'b0;
		end else begin
			if (state_q == StOut) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				count_q <= cfg_sat; total_q <= '0; clr_q <= '0; state_q <= StClr;
			end else begin
				unique case (state_q)
					StClr: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == IdxW'(bpsuf_pkg::MaxNodes - 1)) state_q <= StIdle;
					end
					StIdle: if (edges.valid && edges.ready) begin
						a_q <= edges.data.node_a; b_q <= edges.data.node_b;
						cap_q <= edges.data.capacity;
						if (CntW'(edges.data.node_a) >= count_q ||
								CntW'(edges.data.node_b) >= count_q) begin
							joined_q <= 1'b0; state_q <= StOut;
						end else begin
							cur_q <= edges.data.node_a; second_q <= 1'b0; state_q <= StFRd;
						end
					end
					StFRd: state_q <= StFChk;
					StFChk: begin
						if (p_rd_q == cur_q) begin
							if (!second_q) begin
								ra_q <= cur_q; cur_q <= b_q; second_q <= 1'b1; state_q <= StFRd;
							end else if (cur_q == ra_q) begin
								joined_q <= 1'b0; state_q <= StOut;
							end else state_q <= StMRd;
						end else state_q <= StFGp;
					end
					StFGp: state_q <= StFLink;
					// p_rd_q holds the grandparent here
					StFLink: begin
						cur_q <= p_rd_q; state_q <= StFRd;
					end
					StMRd: state_q <= StMWait;
					StMWait: begin
						sza_q <= s_rd_q; mina_q <= c_rd_q; state_q <= StMWait2;
					end
					StMWait2: begin
						szb_q <= s_rd_q; m_q <= m_sel; state_q <= StMul1;
					end
					StMul1: begin
						prod_q <= mul_p; state_q <= StMul2;
					end
					StMul2: begin
						prod_q <= mul_p; state_q <= StAdd;
					end
					StAdd: begin
						total_q <= total_q + prod_q[SumW-1:0]; joined_q <= 1'b1; state_q <= StOut;
					end
					StOut: state_q <= StIdle;
					default: state_q <= StIdle;
				endcase
			end
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		edges.ready |-> state_q == StIdle && !out_valid_q) else $error("ready outside idle");
	a_join_size: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StMul2 |-> sza_q != '0 && szb_q != '0) else $error("zero set size");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready && !cfg_we) |=> results.valid && $stable(results.data))
		else $error("result changed while waiting");
endmodule

// ----- tb/bottleneck_pair_sum_union_find_tb.sv -----
// Self-checking testbench for the bottleneck pair-sum union-find engine.
// Depends on bpsuf_pkg, bpsuf_edge_if, bpsuf_result_if and the top level.
// Directed edge table first, then random edge streams under varied idling.
module bottleneck_pair_sum_union_find_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxNodes = bpsuf_pkg::MaxNodes;
	localparam int IdxW = bpsuf_pkg::IdxW;
	localparam int CntW = bpsuf_pkg::CntW;
	localparam int CapW = bpsuf_pkg::CapW;
	localparam int SumW = bpsuf_pkg::SumW;
	localparam logic [CapW-1:0] CapInit = bpsuf_pkg::CapInit;
	localparam logic [SumW-1:0] FullCap = SumW'(CapInit);

	typedef struct {
		logic [IdxW-1:0] a;
		logic [IdxW-1:0] b;
		logic [CapW-1:0] cap;
		bit              typed;
		logic            joined;
		logic [SumW-1:0] sum;
	} edge_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CntW-1:0] cfg_data = '0;

	bpsuf_edge_if edges_ch();
	bpsuf_result_if results_ch();

	bottleneck_pair_sum_union_find dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.edges(edges_ch.sink), .results(results_ch.source)
	);

	// shadow of the disjoint-set state
	logic [IdxW-1:0] link_mem [MaxNodes];
	logic [CntW-1:0] size_mem [MaxNodes];
	logic [CapW-1:0] mincap_mem [MaxNodes];
	logic [SumW-1:0] running_sum;
	logic [CntW-1:0] nodes_used;

	bpsuf_pkg::result_item_t pending_results[$];
	int errors = 0;
	int accepted = 0;
	int delivered = 0;
	int joins_seen = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	bit hold_req = 0;

	function automatic void clear_sets();
		for (int k = 0; k < MaxNodes; k++) begin
			link_mem[k] = k[IdxW-1:0];
			size_mem[k] = CntW'(1);
			mincap_mem[k] = CapInit;
		end
		running_sum = '0;
	endfunction

	function automatic logic [IdxW-1:0] find_root(input logic [IdxW-1:0] x);
		logic [IdxW-1:0] cur;
		cur = x;
		while (link_mem[cur] != cur) begin
			link_mem[cur] = link_mem[link_mem[cur]];
			cur = link_mem[cur];
		end
		return cur;
	endfunction

	function automatic bpsuf_pkg::result_item_t merge_edge(input bpsuf_pkg::edge_item_t e);
		bpsuf_pkg::result_item_t r;
		logic [IdxW-1:0] ra, rb, keep, gone;
		logic [CapW-1:0] m;
		r.joined = 1'b0;
		if (e.node_a >= nodes_used || e.node_b >= nodes_used) begin
			r.pair_sum = running_sum;
			return r;
		end
		ra = find_root(e.node_a);
		rb = find_root(e.node_b);
		if (ra != rb) begin
			// ties put node_a's set under node_b's
			if (size_mem[ra] > size_mem[rb]) begin
				keep = ra;
				gone = rb;
			end else begin
				keep = rb;
				gone = ra;
			end
			m = (mincap_mem[ra] < mincap_mem[rb]) ? mincap_mem[ra] : mincap_mem[rb];
			if (e.capacity < m)
				m = e.capacity;
			mincap_mem[keep] = m;
			running_sum = running_sum + SumW'(m) * SumW'(size_mem[ra]) * SumW'(size_mem[rb]);
			size_mem[keep] = size_mem[keep] + size_mem[gone];
			link_mem[gone] = keep;
			r.joined = 1'b1;
		end
		r.pair_sum = running_sum;
		return r;
	endfunction

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random backpressure plus a long hold-off on request
	initial begin
		results_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				results_ch.ready <= 1'b0;
				for (int c = 0; c < 400; c++)
					@(negedge clk);
			end else begin
				results_ch.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	always @(posedge clk) begin
		bpsuf_pkg::result_item_t want;
		if (results_ch.valid && results_ch.ready) begin
			delivered++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%t unexpected result joined=%0d sum=%0d", $realtime,
					results_ch.data.joined, results_ch.data.pair_sum);
			end else begin
				want = pending_results.pop_front();
				if (results_ch.data.joined !== want.joined) begin
					errors++;
					$display("%t joined mismatch: expected %0d got %0d", $realtime,
						want.joined, results_ch.data.joined);
				end
				if (results_ch.data.pair_sum !== want.pair_sum) begin
					errors++;
					$display("%t pair_sum mismatch: expected %0d got %0d", $realtime,
						want.pair_sum, results_ch.data.pair_sum);
				end
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_edge(input edge_row_t row);
		bpsuf_pkg::edge_item_t e;
		bpsuf_pkg::result_item_t r;
		e.node_a = row.a;
		e.node_b = row.b;
		e.capacity = row.cap;
		if ($urandom_range(99) < tx_idle) begin
			edges_ch.valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		edges_ch.valid <= 1'b1;
		edges_ch.data <= e;
		do @(posedge clk); while (!edges_ch.ready);
		r = merge_edge(e);
		if (row.typed) begin
			r.joined = row.joined;
			r.pair_sum = row.sum;
		end
		pending_results.push_back(r);
		accepted++;
		if (r.joined)
			joins_seen++;
		@(negedge clk);
	endtask

	task automatic drain();
		edges_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_node_count(input logic [CntW-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		nodes_used = (v == 0) ? CntW'(1) : ((v > MaxNodes) ? CntW'(MaxNodes) : v);
		clear_sets();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic edge_row_t plain_row(input int a, input int b, input int cap);
		edge_row_t row;
		row.a = IdxW'(a);
		row.b = IdxW'(b);
		row.cap = CapW'(cap);
		row.typed = 0;
		row.joined = 0;
		row.sum = '0;
		return row;
	endfunction

	function automatic edge_row_t fixed_row(input int a, input int b, input int cap,
			input logic j, input logic [SumW-1:0] s);
		edge_row_t row;
		row = plain_row(a, b, cap);
		row.typed = 1;
		row.joined = j;
		row.sum = s;
		return row;
	endfunction

	// random stream: mostly descending capacities over in-range nodes, some noise
	task automatic random_phase(input int count, input int nodes);
		logic [CapW-1:0] cap;
		int a, b;
		cap = CapW'(CapInit - $urandom_range(1000));
		for (int i = 0; i < count; i++) begin
			if (i == count / 3)
				hold_req = 1;
			if ($urandom_range(99) < 8) begin
				a = $urandom_range(1023);
				b = $urandom_range(1023);
				cap = CapW'($urandom);
			end else begin
				a = $urandom_range(nodes - 1);
				b = $urandom_range(nodes - 1);
				if ($urandom_range(9) == 0)
					cap = CapW'($urandom);
				else if (cap > 20000000)
					cap = CapW'(cap - $urandom_range(20000000));
			end
			send_edge(plain_row(a, b, cap));
		end
	endtask

	edge_row_t directed[$];

	initial begin
		edges_ch.valid = 1'b0;
		edges_ch.data = '0;
		nodes_used = CntW'(MaxNodes);
		clear_sets();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed.push_back(fixed_row(0, 1, CapInit, 1, FullCap));
		directed.push_back(fixed_row(1, 0, 5, 0, FullCap));
		directed.push_back(fixed_row(1023, 1022, 0, 1, FullCap));
		directed.push_back(fixed_row(2, 2, 100, 0, FullCap));
		directed.push_back(plain_row(0, 1023, 7));
		directed.push_back(plain_row(3, 4, 600));
		directed.push_back(plain_row(5, 3, 500));
		directed.push_back(plain_row(4, 0, 400));
		directed.push_back(plain_row(512, 511, 'h2AAAAAAA));
		directed.push_back(plain_row(341, 682, 'h15555555));
		directed.push_back(plain_row(1022, 5, 3));
		foreach (directed[i])
			send_edge(directed[i]);

		// zero is taken as one node
		write_node_count(0);
		send_edge(fixed_row(0, 0, 9, 0, '0));
		send_edge(fixed_row(1, 0, 9, 0, '0));
		send_edge(fixed_row(1023, 1023, 9, 0, '0));
		// oversized count saturates
		write_node_count('1);
		send_edge(fixed_row(1023, 0, 1, 1, 1));
		send_edge(fixed_row(1023, 1023, 1, 0, 1));
		write_node_count(2);
		send_edge(fixed_row(0, 2, 5, 0, '0));
		send_edge(fixed_row(1, 0, 5, 1, 5));

		tx_idle = 12;
		rx_idle = 47;
		write_node_count(16);
		random_phase(300, 16);
		write_node_count(CntW'(MaxNodes));
		random_phase(280, 1024);
		// sender waits for every result before carrying on
		drain();

		tx_idle = 47;
		rx_idle = 12;
		write_node_count(64);
		random_phase(300, 64);
		write_node_count(1);
		random_phase(40, 1);
		write_node_count(8);
		random_phase(250, 8);

		tx_idle = 0;
		rx_idle = 0;
		write_node_count(200);
		random_phase(300, 200);
		write_node_count(1023);
		random_phase(280, 1023);

		drain();
		$display("covered %0d edges, %0d results, %0d merges over node counts 1 to 1024",
			accepted, delivered, joins_seen);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches found", errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// ----- bottleneck_pair_sum_union_find.f -----
rtl/bpsuf_pkg.sv
rtl/bpsuf_edge_if.sv
rtl/bpsuf_result_if.sv
rtl/bottleneck_pair_sum_union_find.sv
tb/bottleneck_pair_sum_union_find_tb.sv
